// File: rtl/sip_pkg.sv
// Shared types for the segment intersection point pipeline.
`timescale 1ns / 1ps

package sip_pkg;

   typedef struct packed {
      logic valid;
      logic hit;
      logic neg_x;
      logic neg_y;
   } ctrl_type;

endpackage

// File: rtl/sip_divider.sv
// Pipelined restoring divider for both point coordinates, one quotient bit per stage.
`timescale 1ns / 1ps

module sip_divider #(
   parameter int QW = 17,
   parameter int PW = 35,
   parameter int SW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sip_pkg::ctrl_type    in_ctrl,
   input  logic [PW-1:0]        in_den,
   input  logic [QW+PW-1:0]     in_num_x,
   input  logic [QW+PW-1:0]     in_num_y,
   input  logic [SW-1:0]        in_side,
   output sip_pkg::ctrl_type    out_ctrl,
   output logic [QW-1:0]        out_q_x,
   output logic [QW-1:0]        out_q_y,
   output logic                 out_rnz_x,
   output logic                 out_rnz_y,
   output logic [SW-1:0]        out_side
);

   sip_pkg::ctrl_type ctrl_ff [0:QW];
   logic [PW-1:0]     den_ff  [0:QW];
   logic [PW-1:0]     rx_ff   [0:QW];
   logic [PW-1:0]     ry_ff   [0:QW];
   logic [QW-1:0]     lx_ff   [0:QW];
   logic [QW-1:0]     ly_ff   [0:QW];
   logic [QW-1:0]     qx_ff   [0:QW];
   logic [QW-1:0]     qy_ff   [0:QW];
   logic [SW-1:0]     side_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff[0] <= '0;
      end else begin
         ctrl_ff[0] <= in_ctrl;
      end
      den_ff[0]  <= in_den;
      rx_ff[0]   <= in_num_x[QW+PW-1:QW];
      ry_ff[0]   <= in_num_y[QW+PW-1:QW];
      lx_ff[0]   <= in_num_x[QW-1:0];
      ly_ff[0]   <= in_num_y[QW-1:0];
      qx_ff[0]   <= '0;
      qy_ff[0]   <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [PW:0]   sx_in;
      logic [PW:0]   sy_in;
      logic          gx_in;
      logic          gy_in;
      logic [PW:0]   dx_in;
      logic [PW:0]   dy_in;

      always_comb begin
         sx_in = {rx_ff[k], lx_ff[k][QW-1]};
         sy_in = {ry_ff[k], ly_ff[k][QW-1]};
         gx_in = sx_in >= {1'b0, den_ff[k]};
         gy_in = sy_in >= {1'b0, den_ff[k]};
         dx_in = sx_in - {1'b0, den_ff[k]};
         dy_in = sy_in - {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[k+1] <= '0;
         end else begin
            ctrl_ff[k+1] <= ctrl_ff[k];
         end
         den_ff[k+1]  <= den_ff[k];
         rx_ff[k+1]   <= gx_in ? dx_in[PW-1:0] : sx_in[PW-1:0];
         ry_ff[k+1]   <= gy_in ? dy_in[PW-1:0] : sy_in[PW-1:0];
         lx_ff[k+1]   <= {lx_ff[k][QW-2:0], 1'b0};
         ly_ff[k+1]   <= {ly_ff[k][QW-2:0], 1'b0};
         qx_ff[k+1]   <= {qx_ff[k][QW-2:0], gx_in};
         qy_ff[k+1]   <= {qy_ff[k][QW-2:0], gy_in};
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_ctrl  = ctrl_ff[QW];
   assign out_q_x   = qx_ff[QW];
   assign out_q_y   = qy_ff[QW];
   assign out_rnz_x = |rx_ff[QW];
   assign out_rnz_y = |ry_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

// File: rtl/segment_intersection_point.sv
// Top level of the segment intersection point pipeline.
`timescale 1ns / 1ps

// One item enters per clock and busy stays low; each result appears on rsp_valid
// once its item has passed the difference, product, sign and numerator registers,
// the divider and the output register; the bit-per-stage divider scales the ray
// by uA. The receiver cannot stall, so results are never held back.
module segment_intersection_point #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_ray_start_x,
   input  logic [COORD_WIDTH-1:0] req_ray_start_y,
   input  logic [COORD_WIDTH-1:0] req_ray_end_x,
   input  logic [COORD_WIDTH-1:0] req_ray_end_y,
   input  logic [COORD_WIDTH-1:0] req_edge_start_x,
   input  logic [COORD_WIDTH-1:0] req_edge_start_y,
   input  logic [COORD_WIDTH-1:0] req_edge_end_x,
   input  logic [COORD_WIDTH-1:0] req_edge_end_y,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [COORD_WIDTH-1:0] rsp_cross_x,
   output logic [COORD_WIDTH-1:0] rsp_cross_y
);

   localparam int CW = (COORD_WIDTH < 30) ? COORD_WIDTH : 30;
   localparam int D  = CW + 1;
   localparam int P  = 2 * D + 1;
   localparam int NW = D + P;
   localparam int SW = 2 * CW;
   localparam int RW = COORD_WIDTH + 2;
   localparam logic [COORD_WIDTH-1:0] MISS_COORD =
      COORD_WIDTH'(0) - (COORD_WIDTH'(1) << FRAC_BITS);

   sip_pkg::ctrl_type ctrl_ff [1:6];
   logic [SW-1:0]     base_ff [1:6];
   logic [D-1:0]      magx_ff [1:5];
   logic [D-1:0]      magy_ff [1:5];

   logic signed [CW-1:0] sx_in, sy_in, tx_in, ty_in, gx_in, gy_in, hx_in, hy_in;
   logic signed [D-1:0]  rx_in, ry_in;
   logic signed [D-1:0]  rx_ff, ry_ff, ex_ff, ey_ff, ox_ff, oy_ff;
   logic signed [2*D-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [P-1:0]  den_ff, na_ff, nb_ff;
   logic signed [P-1:0]  den4_ff, na4_ff, nb4_ff;
   logic [P-1:0]         den5_ff, na5_ff;
   logic                 hit_in;
   logic [P-1:0]         den6_ff;
   logic [NW-1:0]        numx_ff, numy_ff;

   sip_pkg::ctrl_type    dctrl;
   logic [D-1:0]         qx, qy;
   logic                 rnzx, rnzy;
   logic [SW-1:0]        dside;
   logic signed [RW-1:0] bx_in, by_in, cx_in, cy_in;

   assign busy = 1'b0;

   always_comb begin
      sx_in = req_ray_start_x[CW-1:0];
      sy_in = req_ray_start_y[CW-1:0];
      tx_in = req_ray_end_x[CW-1:0];
      ty_in = req_ray_end_y[CW-1:0];
      gx_in = req_edge_start_x[CW-1:0];
      gy_in = req_edge_start_y[CW-1:0];
      hx_in = req_edge_end_x[CW-1:0];
      hy_in = req_edge_end_y[CW-1:0];
      rx_in = D'(tx_in) - D'(sx_in);
      ry_in = D'(ty_in) - D'(sy_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 6; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else begin
         ctrl_ff[1] <= '{valid: start, hit: 1'b0, neg_x: rx_in[D-1], neg_y: ry_in[D-1]};
         for (int i = 2; i <= 5; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
         ctrl_ff[6] <= '{valid: ctrl_ff[5].valid, hit: hit_in,
                         neg_x: ctrl_ff[5].neg_x, neg_y: ctrl_ff[5].neg_y};
      end
      base_ff[1] <= {sx_in, sy_in};
      magx_ff[1] <= rx_in[D-1] ? D'(-rx_in) : rx_in;
      magy_ff[1] <= ry_in[D-1] ? D'(-ry_in) : ry_in;
      for (int i = 2; i <= 6; i++) begin
         base_ff[i] <= base_ff[i-1];
      end
      for (int i = 2; i <= 5; i++) begin
         magx_ff[i] <= magx_ff[i-1];
         magy_ff[i] <= magy_ff[i-1];
      end
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      ex_ff <= D'(hx_in) - D'(gx_in);
      ey_ff <= D'(hy_in) - D'(gy_in);
      ox_ff <= D'(sx_in) - D'(gx_in);
      oy_ff <= D'(sy_in) - D'(gy_in);
      p0_ff <= ey_ff * rx_ff;
      p1_ff <= ex_ff * ry_ff;
      p2_ff <= ex_ff * oy_ff;
      p3_ff <= ey_ff * ox_ff;
      p4_ff <= rx_ff * oy_ff;
      p5_ff <= ry_ff * ox_ff;
      den_ff <= P'(p0_ff) - P'(p1_ff);
      na_ff  <= P'(p2_ff) - P'(p3_ff);
      nb_ff  <= P'(p4_ff) - P'(p5_ff);
      den4_ff <= den_ff[P-1] ? -den_ff : den_ff;
      na4_ff  <= den_ff[P-1] ? -na_ff : na_ff;
      nb4_ff  <= den_ff[P-1] ? -nb_ff : nb_ff;
      den5_ff <= den4_ff;
      na5_ff  <= na4_ff;
      den6_ff <= den5_ff;
      numx_ff <= NW'(magx_ff[5]) * NW'(na5_ff);
      numy_ff <= NW'(magy_ff[5]) * NW'(na5_ff);
   end

   always_comb begin
      hit_in = (den5_ff != '0) && !na5_ff[P-1] && (na5_ff <= den5_ff);
   end

   logic hit5_ff;

   always_ff @(posedge clock) begin
      hit5_ff <= (den4_ff != '0) && !na4_ff[P-1] && !nb4_ff[P-1]
                 && (na4_ff <= den4_ff) && (nb4_ff <= den4_ff);
   end

   sip_pkg::ctrl_type div_ctrl;
   logic hit5_q_ff;

   always_comb begin
      div_ctrl     = ctrl_ff[6];
      div_ctrl.hit = ctrl_ff[6].hit & hit5_q_ff;
   end

   always_ff @(posedge clock) begin
      hit5_q_ff <= hit5_ff;
   end

   sip_divider #(
      .QW(D),
      .PW(P),
      .SW(SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_ctrl   (div_ctrl),
      .in_den    (den6_ff),
      .in_num_x  (numx_ff),
      .in_num_y  (numy_ff),
      .in_side   (base_ff[6]),
      .out_ctrl  (dctrl),
      .out_q_x   (qx),
      .out_q_y   (qy),
      .out_rnz_x (rnzx),
      .out_rnz_y (rnzy),
      .out_side  (dside)
   );

   always_comb begin
      bx_in = RW'($signed(dside[SW-1:CW]));
      by_in = RW'($signed(dside[CW-1:0]));
      if (!dctrl.neg_x) begin
         cx_in = bx_in + $signed({{(RW-D){1'b0}}, qx});
         if (rnzx && cx_in[RW-1]) begin
            cx_in = cx_in + RW'(1);
         end
      end else begin
         cx_in = bx_in - $signed({{(RW-D){1'b0}}, qx});
         if (rnzx && !cx_in[RW-1] && (cx_in != '0)) begin
            cx_in = cx_in - RW'(1);
         end
      end
      if (!dctrl.neg_y) begin
         cy_in = by_in + $signed({{(RW-D){1'b0}}, qy});
         if (rnzy && cy_in[RW-1]) begin
            cy_in = cy_in + RW'(1);
         end
      end else begin
         cy_in = by_in - $signed({{(RW-D){1'b0}}, qy});
         if (rnzy && !cy_in[RW-1] && (cy_in != '0)) begin
            cy_in = cy_in - RW'(1);
         end
      end
   end

   logic                   valid_ff;
   logic                   hit_ff;
   logic [COORD_WIDTH-1:0] crx_ff, cry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dctrl.valid;
      end
      hit_ff <= dctrl.hit;
      crx_ff <= dctrl.hit ? cx_in[COORD_WIDTH-1:0] : MISS_COORD;
      cry_ff <= dctrl.hit ? cy_in[COORD_WIDTH-1:0] : MISS_COORD;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_cross_x = crx_ff;
   assign rsp_cross_y = cry_ff;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the segment intersection point pipeline.
`timescale 1ns / 1ps

module tb_top;

   localparam int CW = 16;
   localparam int FB = 4;

   typedef logic [7:0][CW-1:0] segs_type;

   typedef struct {
      logic          hit;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
   } crossing_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   segs_type      req = '0;
   logic          rsp_valid;
   logic          rsp_hit;
   logic [CW-1:0] rsp_cross_x;
   logic [CW-1:0] rsp_cross_y;

   segs_type     pending_q[$];
   crossing_type crossing_q[$];
   int        n_accepted = 0;
   int        n_mismatch = 0;
   int        sender_idle_pct = 34;
   bit        paused_done = 1'b0;
   bit        failed = 1'b0;

   segment_intersection_point #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ray_start_x(req[0]), .req_ray_start_y(req[1]),
      .req_ray_end_x(req[2]), .req_ray_end_y(req[3]),
      .req_edge_start_x(req[4]), .req_edge_start_y(req[5]),
      .req_edge_end_x(req[6]), .req_edge_end_y(req[7]),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Truncates base + num * delta / den toward zero, with den positive.
   function automatic longint point_on_ray(longint base, longint delta, longint num,
                                           longint den);
      longint prod, mag, q, r, v;
      prod = num * delta;
      mag  = (prod < 0) ? -prod : prod;
      q    = mag / den;
      r    = mag % den;
      if (prod >= 0) begin
         v = base + q;
         if (r != 0 && v < 0) v = v + 1;
      end else begin
         v = base - q;
         if (r != 0 && v > 0) v = v - 1;
      end
      return v;
   endfunction

   function automatic crossing_type predict_crossing(segs_type s);
      longint       sx, sy, rx, ry, ex, ey, ox, oy, den, na, nb;
      crossing_type c;
      sx  = longint'($signed(s[0]));
      sy  = longint'($signed(s[1]));
      rx  = longint'($signed(s[2])) - sx;
      ry  = longint'($signed(s[3])) - sy;
      ex  = longint'($signed(s[6])) - longint'($signed(s[4]));
      ey  = longint'($signed(s[7])) - longint'($signed(s[5]));
      ox  = sx - longint'($signed(s[4]));
      oy  = sy - longint'($signed(s[5]));
      den = ey * rx - ex * ry;
      na  = ex * oy - ey * ox;
      nb  = rx * oy - ry * ox;
      if (den < 0) begin
         den = -den;
         na  = -na;
         nb  = -nb;
      end
      c.hit = (den != 0 && na >= 0 && na <= den && nb >= 0 && nb <= den);
      if (c.hit) begin
         c.x = CW'(point_on_ray(sx, rx, na, den));
         c.y = CW'(point_on_ray(sy, ry, na, den));
      end else begin
         c.x = CW'(-(longint'(1) << FB));
         c.y = c.x;
      end
      return c;
   endfunction

   function automatic segs_type make_segs(int a, int b, int c, int d, int e, int f, int g,
                                          int h);
      segs_type s;
      s[0] = CW'(a); s[1] = CW'(b); s[2] = CW'(c); s[3] = CW'(d);
      s[4] = CW'(e); s[5] = CW'(f); s[6] = CW'(g); s[7] = CW'(h);
      return s;
   endfunction

   function automatic int near(int centre, int spread);
      int v;
      v = centre + $urandom_range(2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic segs_type random_segs();
      segs_type s;
      int    cx, cy, sp, k;
      k  = $urandom_range(9);
      cx = near(0, 30000);
      cy = near(0, 30000);
      sp = 1 << $urandom_range(11, 1);
      case (k)
         0, 1: begin
            for (int i = 0; i < 8; i++) s[i] = CW'($urandom);
         end
         2: begin
            s = make_segs(cx, cy, near(cx, sp), near(cy, sp), cx, cy, cx, cy);
            s[6] = s[2]; s[7] = s[3];
            if ($urandom_range(1)) s[4] = s[2];
         end
         3: begin
            s = make_segs(cx, cy, near(cx, sp), near(cy, sp), 0, 0, 0, 0);
            s[4] = s[2]; s[5] = s[3];
            s[6] = CW'(near(int'($signed(s[2])), sp));
            s[7] = CW'(near(int'($signed(s[3])), sp));
         end
         default: begin
            s = make_segs(near(cx, sp), near(cy, sp), near(cx, sp), near(cy, sp),
                          near(cx, sp), near(cy, sp), near(cx, sp), near(cy, sp));
         end
      endcase
      return s;
   endfunction

   // Driver: presents the head of the pending queue at the falling edge.
   always @(negedge clock) begin
      if (reset || pending_q.size() == 0) begin
         start <= 1'b0;
      end else if (!paused_done && n_accepted >= 700) begin
         start <= 1'b0;
         if (crossing_q.size() == 0) paused_done = 1'b1;
      end else if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req   <= pending_q[0];
      end
   end

   // Monitor: records accepted items and checks every result strobe.
   always @(posedge clock) begin
      crossing_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (crossing_q.size() == 0) begin
               failed = 1'b1;
               if (n_mismatch < 10)
                  $display("Unexpected result: hit=%0b x=%h y=%h",
                           rsp_hit, rsp_cross_x, rsp_cross_y);
               n_mismatch++;
            end else begin
               e = crossing_q.pop_front();
               if (e.hit !== rsp_hit || e.x !== rsp_cross_x || e.y !== rsp_cross_y) begin
                  failed = 1'b1;
                  if (n_mismatch < 10)
                     $display("Mismatch: expected hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
                              e.hit, e.x, e.y, rsp_hit, rsp_cross_x, rsp_cross_y);
                  n_mismatch++;
               end
            end
         end
         if (start && !busy) begin
            crossing_q.push_back(predict_crossing(req));
            void'(pending_q.pop_front());
            n_accepted++;
            if (n_accepted == 700) sender_idle_pct = 75;
            if (n_accepted == 1400) sender_idle_pct = 0;
         end
      end
   end

   initial begin
      pending_q.push_back(make_segs(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      pending_q.push_back(make_segs(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
      pending_q.push_back(make_segs(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
      pending_q.push_back(make_segs(0, 0, 160, 160, 0, 160, 160, 0));
      pending_q.push_back(make_segs(0, 0, 160, 0, 0, 16, 160, 16));
      pending_q.push_back(make_segs(0, 0, 160, 0, 80, 0, 320, 0));
      pending_q.push_back(make_segs(5, 5, 5, 5, 0, 0, 16, 16));
      pending_q.push_back(make_segs(0, 0, 160, 0, 160, -16, 160, 16));
      pending_q.push_back(make_segs(0, 0, 160, 0, 0, 0, 0, 160));
      pending_q.push_back(make_segs(0, 0, 160, 0, 80, 0, 80, 160));
      pending_q.push_back(make_segs(0, 0, 160, 0, 80, 1, 80, 160));
      pending_q.push_back(make_segs(-1, -1, -7, -3, -5, 0, -3, -5));
      pending_q.push_back(make_segs(3, 7, -10, -2, -4, 9, 1, -8));
      pending_q.push_back(make_segs(0, 0, 0, 0, 0, 0, 0, 0));
      pending_q.push_back(make_segs(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
      pending_q.push_back(make_segs(0, 0, 10, 10, 20, 0, 30, -10));
      for (int i = 0; i < 2000; i++) pending_q.push_back(random_segs());
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      wait (crossing_q.size() == 0);
      repeat (40) @(posedge clock);
      if (!failed && crossing_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
